/* sv/ffpa_pkg.sv */
// Types, codes and constants shared by the first-fit partition allocator.
package ffpa_pkg;

    // Fixed field widths
    localparam int SIZE_W   = 20;
    localparam int OWNER_W  = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    localparam logic [SIZE_W-1:0] TOTAL_RESET = 20'd1000;

    // Request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

    // Request beat
    typedef struct packed {
        logic               opcode;
        logic [OWNER_W-1:0] process_id;
        logic [SIZE_W-1:0]  request_size;
    } ffpa_req_t;

    // Result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   block_size;
        logic [SLOT_W-1:0]   block_slot;
    } ffpa_res_t;

    // Per-field write enables into the partition table
    typedef struct packed {
        logic size_en;
        logic owner_en;
        logic link_en;
    } ffpa_we_t;

    // Outcome of the shared compare unit
    typedef struct packed {
        logic              fits;
        logic              exact;
        logic              owner_eq;
        logic [SIZE_W-1:0] diff;
    } ffpa_cmp_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_RD,
        S_CHK,
        S_SPLIT,
        S_TAKE,
        S_UNLINK,
        S_RELINK,
        S_DONE
    } ffpa_state_t;

endpackage

/* sv/ffpa_table.sv */
// Partition table: size, owner and link memories with one write and one registered read port.
module ffpa_table #(
    parameter int SW = 4,
    parameter int LW = 5
) (
    input  logic                     clk,
    input  ffpa_pkg::ffpa_we_t       we,
    input  logic [SW-1:0]            wr_addr,
    input  logic [ffpa_pkg::SIZE_W-1:0]  wr_size,
    input  logic [ffpa_pkg::OWNER_W-1:0] wr_owner,
    input  logic [LW-1:0]            wr_link,
    input  logic [SW-1:0]            rd_addr,
    output logic [ffpa_pkg::SIZE_W-1:0]  rd_size,
    output logic [ffpa_pkg::OWNER_W-1:0] rd_owner,
    output logic [LW-1:0]            rd_link
);
    import ffpa_pkg::*;

    localparam int DEPTH = 1 << SW;

    logic [SIZE_W-1:0]  size_reg  [DEPTH];
    logic [OWNER_W-1:0] owner_reg [DEPTH];
    logic [LW-1:0]      link_reg  [DEPTH];

    logic [SIZE_W-1:0]  rd_size_reg;
    logic [OWNER_W-1:0] rd_owner_reg;
    logic [LW-1:0]      rd_link_reg;

    // Write the selected fields of one entry
    always_ff @(posedge clk)
    begin
        if (we.size_en)
        begin
            size_reg[wr_addr] <= wr_size;
        end
        if (we.owner_en)
        begin
            owner_reg[wr_addr] <= wr_owner;
        end
        if (we.link_en)
        begin
            link_reg[wr_addr] <= wr_link;
        end
    end

    // Register the read of one entry
    always_ff @(posedge clk)
    begin
        rd_size_reg  <= size_reg[rd_addr];
        rd_owner_reg <= owner_reg[rd_addr];
        rd_link_reg  <= link_reg[rd_addr];
    end

    assign rd_size  = rd_size_reg;
    assign rd_owner = rd_owner_reg;
    assign rd_link  = rd_link_reg;

endmodule

/* sv/ffpa_unit.sv */
// Shared compare unit: size fit test with remainder, and owner match.
module ffpa_unit (
    input  logic [ffpa_pkg::SIZE_W-1:0]  part_size,
    input  logic [ffpa_pkg::SIZE_W-1:0]  req_size,
    input  logic [ffpa_pkg::OWNER_W-1:0] part_owner,
    input  logic [ffpa_pkg::OWNER_W-1:0] req_owner,
    output ffpa_pkg::ffpa_cmp_t          cmp
);
    import ffpa_pkg::*;

    logic [SIZE_W:0] sub;

    // Subtract with borrow: no borrow means the partition is large enough
    assign sub          = {1'b0, part_size} - {1'b0, req_size};
    assign cmp.fits     = ~sub[SIZE_W];
    assign cmp.exact    = (sub == '0);
    assign cmp.diff     = sub[SIZE_W-1:0];
    assign cmp.owner_eq = (part_owner == req_owner);

endmodule

/* sv/first_fit_partition_allocator.sv */
// Top level of the first-fit partition allocator: request sequencer, usage bits and result register.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+-------------------------------
//  in      | in        | in_valid / in_ready  | ffpa_req_t (opcode, id, size)
//  out     | out       | out_valid / out_ready| ffpa_res_t (status, size, slot)
//  cfg     | in        | cfg_we               | total_memory, 20 bits
//
// Each list entry visited passes a table read state and then a compare state; the first
// request after reset also passes an init state, where slot 0 is loaded from total_memory.
// Reset clears the usage bits, list head and slot count; the table is written before read.
// in_ready is high only in idle; a finished result waits in the output register,
// and a new request may be accepted meanwhile.
module first_fit_partition_allocator #(
    parameter int MAX_PARTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ffpa_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ffpa_pkg::ffpa_req_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ffpa_pkg::ffpa_res_t           out_data
);
    import ffpa_pkg::*;

    localparam int SW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int LW = $clog2(MAX_PARTS + 1);
    localparam logic [LW-1:0] LINK_END = LW'(MAX_PARTS);

    ffpa_state_t state_reg, state_next;

    logic [SIZE_W-1:0]    total_reg;
    logic [MAX_PARTS-1:0] used_reg, used_next;
    logic [LW-1:0]        head_reg, head_next;
    logic [LW-1:0]        slots_reg, slots_next;
    logic [LW-1:0]        cur_reg, cur_next;
    logic [LW-1:0]        prev_reg, prev_next;
    logic [LW-1:0]        cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    ffpa_req_t            req_reg, req_next;
    logic [SIZE_W-1:0]    hold_size_reg, hold_size_next;
    logic [SIZE_W-1:0]    diff_reg, diff_next;
    logic [LW-1:0]        hold_link_reg, hold_link_next;
    ffpa_res_t            res_reg, res_next;
    ffpa_res_t            out_reg, out_next;

    ffpa_we_t             we;
    logic [SW-1:0]        wr_addr;
    logic [SIZE_W-1:0]    wr_size;
    logic [OWNER_W-1:0]   wr_owner;
    logic [LW-1:0]        wr_link;
    logic [SIZE_W-1:0]    rd_size;
    logic [OWNER_W-1:0]   rd_owner;
    logic [LW-1:0]        rd_link;
    ffpa_cmp_t            cmp;

    logic [SW-1:0]        cur_slot;
    logic [SW-1:0]        new_slot;
    logic [SW+3:0]        slot_wide;
    logic                 cur_used;

    assign cur_slot  = cur_reg[SW-1:0];
    assign new_slot  = slots_reg[SW-1:0];
    assign slot_wide = {4'b0000, cur_slot};
    assign cur_used  = used_reg[cur_slot];

    ffpa_table #(
        .SW (SW),
        .LW (LW)
    ) u_table (
        .clk      (clk),
        .we       (we),
        .wr_addr  (wr_addr),
        .wr_size  (wr_size),
        .wr_owner (wr_owner),
        .wr_link  (wr_link),
        .rd_addr  (cur_slot),
        .rd_size  (rd_size),
        .rd_owner (rd_owner),
        .rd_link  (rd_link)
    );

    ffpa_unit u_unit (
        .part_size  (rd_size),
        .req_size   (req_reg.request_size),
        .part_owner (rd_owner),
        .req_owner  (req_reg.process_id),
        .cmp        (cmp)
    );

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            total_reg <= cfg_wdata;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            head_reg      <= '0;
            slots_reg     <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            head_reg      <= head_next;
            slots_reg     <= slots_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        hold_size_reg <= hold_size_next;
        diff_reg      <= diff_next;
        hold_link_reg <= hold_link_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    // Sequencer: walk the list, then split, take, unlink or relink
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        head_next      = head_reg;
        slots_next     = slots_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        req_next       = req_reg;
        hold_size_next = hold_size_reg;
        diff_next      = diff_reg;
        hold_link_next = hold_link_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        we             = '0;
        wr_addr        = cur_slot;
        wr_size        = req_reg.request_size;
        wr_owner       = req_reg.process_id;
        wr_link        = hold_link_reg;
        in_ready       = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next  = in_data;
                    cur_next  = head_reg;
                    prev_next = LINK_END;
                    cnt_next  = '0;
                    state_next = (slots_reg == '0) ? S_INIT : S_RD;
                end
            end

            S_INIT:
            begin
                // Load slot 0 as one free partition
                we         = '{size_en: 1'b1, owner_en: 1'b1, link_en: 1'b1};
                wr_addr    = '0;
                wr_size    = total_reg;
                wr_owner   = '0;
                wr_link    = LINK_END;
                used_next[0] = 1'b0;
                head_next  = '0;
                cur_next   = '0;
                slots_next = LW'(1);
                state_next = S_RD;
            end

            S_RD:
            begin
                if ((cur_reg >= LINK_END) || (cnt_reg >= LINK_END))
                begin
                    res_next.status     = (req_reg.opcode == OP_ALLOC) ? ST_NO_MEMORY
                                                                       : ST_NOT_FOUND;
                    res_next.block_size = '0;
                    res_next.block_slot = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                hold_link_next = rd_link;
                hold_size_next = rd_size;
                diff_next      = cmp.diff;
                if (req_reg.opcode == OP_ALLOC)
                begin
                    if (!cur_used && cmp.fits)
                    begin
                        if (cmp.exact)
                        begin
                            state_next = S_TAKE;
                        end
                        else if (slots_reg >= LINK_END)
                        begin
                            res_next.status     = ST_TABLE_FULL;
                            res_next.block_size = '0;
                            res_next.block_slot = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SPLIT;
                        end
                    end
                    else
                    begin
                        prev_next  = cur_reg;
                        cur_next   = rd_link;
                        cnt_next   = cnt_reg + LW'(1);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (cur_used && cmp.owner_eq)
                    begin
                        used_next[cur_slot] = 1'b0;
                        if (prev_reg < LINK_END)
                        begin
                            state_next = S_UNLINK;
                        end
                        else
                        begin
                            head_next  = rd_link;
                            state_next = S_RELINK;
                        end
                    end
                    else
                    begin
                        prev_next  = cur_reg;
                        cur_next   = rd_link;
                        cnt_next   = cnt_reg + LW'(1);
                        state_next = S_RD;
                    end
                end
            end

            S_SPLIT:
            begin
                // Place the free remainder in the next unused slot
                we             = '{size_en: 1'b1, owner_en: 1'b1, link_en: 1'b1};
                wr_addr        = new_slot;
                wr_size        = diff_reg;
                wr_owner       = '0;
                wr_link        = hold_link_reg;
                used_next[new_slot] = 1'b0;
                hold_link_next = slots_reg;
                slots_next     = slots_reg + LW'(1);
                state_next     = S_TAKE;
            end

            S_TAKE:
            begin
                we = '{size_en: 1'b1, owner_en: 1'b1, link_en: 1'b1};
                used_next[cur_slot] = 1'b1;
                res_next.status     = ST_ALLOCATED;
                res_next.block_size = req_reg.request_size;
                res_next.block_slot = slot_wide[3:0];
                state_next = S_DONE;
            end

            S_UNLINK:
            begin
                // Bridge the predecessor over the freed entry
                we         = '{size_en: 1'b0, owner_en: 1'b0, link_en: 1'b1};
                wr_addr    = prev_reg[SW-1:0];
                wr_link    = hold_link_reg;
                state_next = S_RELINK;
            end

            S_RELINK:
            begin
                // Move the freed entry to the list head
                we         = '{size_en: 1'b0, owner_en: 1'b0, link_en: 1'b1};
                wr_link    = head_reg;
                head_next  = cur_reg;
                res_next.status     = ST_FREED;
                res_next.block_size = hold_size_reg;
                res_next.block_slot = slot_wide[3:0];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Advance the result into the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* verif/tb_first_fit_partition_allocator.sv */
// Self-checking testbench for the first-fit partition allocator, with a shadow partition table.
module tb_first_fit_partition_allocator;
    import ffpa_pkg::*;

    localparam int PARTS       = 16;
    localparam int LINK_END    = PARTS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * PARTS + 8;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [SIZE_W-1:0]  cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    ffpa_req_t          in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ffpa_res_t          out_data;

    // Shadow of the partition table
    logic [SIZE_W-1:0]  part_len [PARTS];
    logic               part_busy [PARTS];
    logic [OWNER_W-1:0] part_pid [PARTS];
    int                 part_next [PARTS];
    int                 list_first;
    int                 slots_taken;
    logic [SIZE_W-1:0]  shadow_total;

    ffpa_req_t          request_queue [$];
    ffpa_res_t          predicted_results [$];
    int                 reqs_queued;
    int                 reqs_accepted;
    int                 error_count;
    int                 cycle_count;
    int                 status_seen [5];
    bit                 idling_on;
    bit                 req_beat_taken;
    int                 in_gap;
    int                 stall_left;

    first_fit_partition_allocator #(
        .MAX_PARTS (PARTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Work out the result of one request and update the shadow table
    function automatic ffpa_res_t apply_request(input ffpa_req_t rq);
        ffpa_res_t r;
        int        cur;
        int        prev;
        int        n;
        int        spare;
        bit        found;
        r = '0;
        // build the list from the total held at the first request
        if (slots_taken == 0)
        begin
            part_len[0]  = shadow_total;
            part_busy[0] = 1'b0;
            part_pid[0]  = '0;
            part_next[0] = LINK_END;
            list_first   = 0;
            slots_taken  = 1;
        end
        if (rq.opcode == OP_ALLOC)
        begin
            cur = list_first;
            n   = 0;
            while (n < PARTS && cur < PARTS &&
                   !(!part_busy[cur] && part_len[cur] >= rq.request_size))
            begin
                cur = part_next[cur];
                n++;
            end
            if (n >= PARTS || cur >= PARTS)
                r.status = ST_NO_MEMORY;
            else if (part_len[cur] > rq.request_size && slots_taken >= PARTS)
                r.status = ST_TABLE_FULL;
            else
            begin
                // split off the remainder into the next unused slot
                if (part_len[cur] > rq.request_size)
                begin
                    spare            = slots_taken;
                    slots_taken++;
                    part_len[spare]  = part_len[cur] - rq.request_size;
                    part_busy[spare] = 1'b0;
                    part_pid[spare]  = '0;
                    part_next[spare] = part_next[cur];
                    part_len[cur]    = rq.request_size;
                    part_next[cur]   = spare;
                end
                part_busy[cur] = 1'b1;
                part_pid[cur]  = rq.process_id;
                r.status       = ST_ALLOCATED;
                r.block_size   = part_len[cur];
                r.block_slot   = SLOT_W'(cur);
            end
        end
        else
        begin
            prev  = LINK_END;
            cur   = list_first;
            n     = 0;
            found = 1'b0;
            while (!found && n < PARTS && cur < PARTS)
            begin
                if (part_busy[cur] && part_pid[cur] == rq.process_id)
                    found = 1'b1;
                else
                begin
                    prev = cur;
                    cur  = part_next[cur];
                    n++;
                end
            end
            if (found)
            begin
                // unlink and move to the head of the list
                part_busy[cur] = 1'b0;
                if (prev < PARTS)
                    part_next[prev] = part_next[cur];
                else
                    list_first = part_next[cur];
                part_next[cur] = list_first;
                list_first     = cur;
                r.status       = ST_FREED;
                r.block_size   = part_len[cur];
                r.block_slot   = SLOT_W'(cur);
            end
            else
                r.status = ST_NOT_FOUND;
        end
        return r;
    endfunction

    // Draw a random request, biased towards exact fits and known owners
    function automatic ffpa_req_t draw_request();
        ffpa_req_t rq;
        int        pick;
        int        cands [$];
        rq            = '0;
        pick          = $urandom_range(0, 99);
        rq.process_id = ($urandom_range(0, 9) < 7) ? OWNER_W'($urandom_range(0, 7))
                                                    : OWNER_W'($urandom());
        if (pick < 65)
        begin
            rq.opcode = OP_ALLOC;
            if (pick < 35)
            begin
                for (int i = 0; i < slots_taken; i++)
                    if (!part_busy[i])
                        cands.push_back(i);
                if (cands.size() > 0)
                    rq.request_size = part_len[cands[$urandom_range(0, cands.size() - 1)]];
                else
                    rq.request_size = SIZE_W'($urandom_range(0, 64));
            end
            else if (pick < 55)
                rq.request_size = SIZE_W'($urandom_range(0, 64));
            else if (pick < 62)
                rq.request_size = SIZE_W'($urandom());
            else
                rq.request_size = '0;
        end
        else
        begin
            rq.opcode       = OP_FREE;
            rq.request_size = SIZE_W'($urandom());
            if (pick < 90)
            begin
                for (int i = 0; i < slots_taken; i++)
                    if (part_busy[i])
                        cands.push_back(i);
                if (cands.size() > 0)
                    rq.process_id = part_pid[cands[$urandom_range(0, cands.size() - 1)]];
            end
            else
                rq.process_id = OWNER_W'($urandom());
        end
        return rq;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic queue_request(input ffpa_req_t rq);
        request_queue.push_back(rq);
        reqs_queued++;
    endtask

    task automatic queue_fields(input logic op, input int pid, input int size);
        ffpa_req_t rq;
        rq.opcode       = op;
        rq.process_id   = OWNER_W'(pid);
        rq.request_size = SIZE_W'(size);
        queue_request(rq);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            while (request_queue.size() >= 2)
                @(posedge clk);
            queue_request(draw_request());
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (reqs_accepted != reqs_queued || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_total(input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we       <= 1'b0;
        shadow_total  = value;
    endtask

    // Drive request beats from the queue, with bursts of idle cycles
    always @(negedge clk)
    begin : drive_requests
        logic hold;
        hold = in_valid && !req_beat_taken;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!hold)
        begin
            if (idling_on && in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (request_queue.size() > 0)
            begin
                in_data  <= request_queue.pop_front();
                in_valid <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 9);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Drive result ready, with bursts of stall cycles
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
            out_ready <= 1'b0;
        else if (idling_on && stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
        end
    end

    // Predict on each request beat and check each result beat
    always @(posedge clk)
    begin : watch_beats
        ffpa_res_t want;
        if (rst_n)
        begin
            req_beat_taken = in_valid && in_ready;
            if (req_beat_taken)
            begin
                predicted_results.push_back(apply_request(in_data));
                reqs_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                    flag_mismatch("result beat with nothing expected, status",
                                  32'(out_data.status), 0);
                else
                begin
                    want = predicted_results.pop_front();
                    if (want.status < 5)
                        status_seen[want.status]++;
                    if (out_data.status !== want.status)
                        flag_mismatch("status", 32'(out_data.status), 32'(want.status));
                    if (out_data.block_size !== want.block_size)
                        flag_mismatch("block_size", 32'(out_data.block_size),
                                      32'(want.block_size));
                    if (out_data.block_slot !== want.block_slot)
                        flag_mismatch("block_slot", 32'(out_data.block_slot),
                                      32'(want.block_slot));
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        int total;
        for (int i = 0; i < PARTS; i++)
        begin
            part_busy[i] = 1'b0;
            part_next[i] = LINK_END;
        end
        list_first   = 0;
        slots_taken  = 0;
        shadow_total = TOTAL_RESET;
        idling_on    = 1'b1;
        total        = $urandom_range(2000, 6000);

        // hold reset, then release on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // only the last write before the first request sets the list size
        write_total('0);
        write_total(SIZE_W'(1));
        write_total(SIZE_W'(20'hFFFFF));
        write_total(SIZE_W'(total));

        // directed: start, zero size, oversize, exact fit, owner misses, table full
        queue_fields(OP_FREE, 9, 0);
        queue_fields(OP_ALLOC, 0, 0);
        queue_fields(OP_ALLOC, 16'hFFFF, 20'hFFFFF);
        queue_fields(OP_ALLOC, 1, 100);
        queue_fields(OP_ALLOC, 16'hFFFF, 200);
        queue_fields(OP_FREE, 16'hFFFF, 20'hFFFFF);
        queue_fields(OP_ALLOC, 2, 200);
        queue_fields(OP_FREE, 1, 0);
        queue_fields(OP_FREE, 1, 0);
        queue_fields(OP_FREE, 0, 0);
        queue_fields(OP_ALLOC, 3, 0);
        queue_fields(OP_ALLOC, 16'h5555, total);
        for (int i = 0; i < 12; i++)
            queue_fields(OP_ALLOC, 16'h0010 + i, 1);
        queue_fields(OP_ALLOC, 16'h0077, 1);
        wait_drained();

        // random phases, with writes that must not disturb a started list
        write_total(SIZE_W'(20'hFFFFF));
        run_random(650);
        wait_drained();
        write_total('0);
        run_random(650);
        wait_drained();
        write_total(SIZE_W'(1));

        // calm tail: no idling on either side
        idling_on = 1'b0;
        run_random(200);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (predicted_results.size() != 0)
            flag_mismatch("results never delivered", 0, predicted_results.size());
        $display("Covered %0d requests against a list of %0d units.", reqs_accepted, total);
        $display("Outcomes: %0d allocated, %0d short, %0d freed, %0d unowned, %0d table full.",
                 status_seen[ST_ALLOCATED], status_seen[ST_NO_MEMORY], status_seen[ST_FREED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_TABLE_FULL]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* first_fit_partition_allocator.f */
sv/ffpa_pkg.sv
sv/ffpa_table.sv
sv/ffpa_unit.sv
sv/first_fit_partition_allocator.sv
verif/tb_first_fit_partition_allocator.sv
